>>> rtl/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types, constants and the status byte classifier for the MIDI
// message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

  // buffer depth range and default
  localparam int DEFAULT_BUFFER_DEPTH = 64;
  localparam int MAX_BUFFER_DEPTH     = 4096;

  // message length field, wide enough for the largest buffer
  localparam int LEN_W = $clog2(MAX_BUFFER_DEPTH + 1);

  // status byte codes
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;
  localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
  localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND  = 4'hE;

  // fixed message lengths
  localparam logic [1:0] LEN_THREE = 2'd3;
  localparam logic [1:0] LEN_TWO   = 2'd2;

  // class of a byte seen while no message is open
  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_FIXED3,
    KIND_FIXED2,
    KIND_SYSEX
  } kind_t;

  // front framing state
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_FIXED,
    FR_SYSEX
  } front_state_t;

  // back emission state
  typedef enum logic {
    BK_IDLE,
    BK_SHOW
  } back_state_t;

  // one finished message waiting to be sent
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             trunc;
  } desc_t;

  // queue status seen by front and back
  typedef struct packed {
    logic  full;
    logic  nonempty;
    logic  wr_bank;
    logic  rd_bank;
    desc_t head;
  } queue_status_t;

  // status byte classifier
  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    k = KIND_DROP;
    if (b[7:4] == HI_NOTE_OFF || b[7:4] == HI_NOTE_ON || b[7:4] == HI_POLY_PRESS ||
        b[7:4] == HI_CTRL_CHANGE || b[7:4] == HI_PITCH_BEND) begin
      k = KIND_FIXED3;
    end else if (b[7:4] == HI_PROG_CHANGE || b[7:4] == HI_CHAN_PRESS) begin
      k = KIND_FIXED2;
    end else if (b == ST_SYSEX_START) begin
      k = KIND_SYSEX;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mmf_ram.sv
// ----------------------------------------------------------------------------
// mmf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mmf_front.sv
// ----------------------------------------------------------------------------
// mmf_front
// Accepts raw bytes, tracks message framing and writes message bytes into
// the current buffer bank; hands each finished message to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_front
  import mmf_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire queue_status_t qstat,
  output logic               push,
  output desc_t              push_desc,
  output logic               wr_en,
  output logic [AW:0]        wr_addr,
  output logic [7:0]         wr_data
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  front_state_t    state, state_next;
  logic [CW-1:0]   fill, fill_next;
  logic            ovf, ovf_next;
  logic [1:0]      exp_len, exp_len_next;
  logic [AW-1:0]   wr_idx;
  logic [CW-1:0]   fill_inc;
  logic            has_room;
  logic            accept;
  logic            is_end;
  kind_t           kind;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;
  assign fill_inc = fill + CW'(1);
  assign has_room = fill < CW'(BUFFER_DEPTH);
  assign is_end   = s_tdata == ST_SYSEX_END;
  assign kind     = classify(s_tdata);
  assign wr_data  = s_tdata;
  assign wr_addr  = {qstat.wr_bank, wr_idx};

  // next framing state
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept && kind == KIND_SYSEX) begin
          state_next = FR_SYSEX;
        end else if (accept && kind != KIND_DROP) begin
          state_next = FR_FIXED;
        end
      end
      FR_FIXED: begin
        if (accept && fill_inc >= CW'(exp_len)) begin
          state_next = FR_IDLE;
        end
      end
      FR_SYSEX: begin
        if (accept && is_end) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // store writes, counters and message hand-off
  always_comb begin
    fill_next       = fill;
    ovf_next        = ovf;
    exp_len_next    = exp_len;
    wr_en           = 1'b0;
    wr_idx          = fill[AW-1:0];
    push            = 1'b0;
    push_desc.len   = LEN_W'(fill_inc);
    push_desc.trunc = 1'b0;
    unique case (state)
      FR_IDLE: begin
        wr_idx = '0;
        if (accept && kind != KIND_DROP) begin
          wr_en        = 1'b1;
          fill_next    = CW'(1);
          ovf_next     = 1'b0;
          exp_len_next = (kind == KIND_FIXED3) ? LEN_THREE :
                         (kind == KIND_FIXED2) ? LEN_TWO : 2'd0;
        end
      end
      FR_FIXED: begin
        if (accept) begin
          wr_en     = 1'b1;
          fill_next = fill_inc;
          if (fill_inc >= CW'(exp_len)) begin
            push      = 1'b1;
            fill_next = '0;
          end
        end
      end
      FR_SYSEX: begin
        if (accept && is_end) begin
          wr_en     = 1'b1;
          push      = 1'b1;
          fill_next = '0;
          ovf_next  = 1'b0;
          if (!has_room) begin
            // full store: end byte overwrites the last entry
            wr_idx          = AW'(BUFFER_DEPTH - 1);
            push_desc.len   = LEN_W'(BUFFER_DEPTH);
            push_desc.trunc = 1'b1;
          end else begin
            push_desc.trunc = ovf;
          end
        end else if (accept) begin
          if (has_room) begin
            wr_en     = 1'b1;
            fill_next = fill_inc;
          end else begin
            ovf_next = 1'b1;
          end
        end
      end
      default: begin
        fill_next = '0;
        ovf_next  = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FR_IDLE;
      fill    <= '0;
      ovf     <= 1'b0;
      exp_len <= '0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      ovf     <= ovf_next;
      exp_len <= exp_len_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mmf_queue.sv
// ----------------------------------------------------------------------------
// mmf_queue
// Two-entry queue of finished message descriptors; its pointers also name
// the buffer bank that the front fills and the back drains.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_queue
  import mmf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire desc_t  push_desc,
  input  wire logic   pop,
  output queue_status_t qstat
);

  desc_t      entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign qstat.full     = count == 2'd2;
  assign qstat.nonempty = count != 2'd0;
  assign qstat.wr_bank  = wr_ptr;
  assign qstat.rd_bank  = rd_ptr;
  assign qstat.head     = entry[rd_ptr];

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mmf_back.sv
// ----------------------------------------------------------------------------
// mmf_back
// Reads a finished message out of its buffer bank and sends it one byte
// per item, with last and truncation marks.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_back
  import mmf_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_status_t qstat,
  output logic               pop,
  output logic               rd_en,
  output logic [AW:0]        rd_addr,
  input  wire logic [7:0]    rd_data,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  back_state_t   state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] rd_idx;
  logic          last;

  assign last    = (CW'(idx) + CW'(1)) == qstat.head.len[CW-1:0];
  assign rd_addr = {qstat.rd_bank, rd_idx};
  assign m_tdata = rd_data;
  assign m_tlast = last;
  assign m_tuser = qstat.head.trunc;

  // next emission state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (qstat.nonempty) begin
          state_next = BK_SHOW;
        end
      end
      BK_SHOW: begin
        if (m_tready && last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // reads, output valid and queue pop
  always_comb begin
    rd_en    = 1'b0;
    rd_idx   = idx + AW'(1);
    idx_next = idx;
    pop      = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      BK_IDLE: begin
        rd_idx   = '0;
        idx_next = '0;
        rd_en    = qstat.nonempty;
      end
      BK_SHOW: begin
        m_tvalid = 1'b1;
        if (m_tready && last) begin
          pop = 1'b1;
        end else if (m_tready) begin
          rd_en    = 1'b1;
          idx_next = rd_idx;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/midi_message_framer_top.sv
// ----------------------------------------------------------------------------
// midi_message_framer_top
// Frames a raw MIDI byte stream into complete messages and re-sends each
// message as a burst of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one raw MIDI byte per item. Note, pressure, controller and
//   pitch bend messages are 3 bytes, program change and channel pressure 2,
//   SysEx runs from 0xF0 to 0xF7. Bytes that open no message are dropped.
//   m_* sends each finished message one byte per item, tlast on its final
//   byte, tuser set on every byte of a SysEx message cut to BUFFER_DEPTH.
//   Input takes one byte per cycle while s_tready is high. The message
//   store has two banks, so one message can be collected while the
//   previous one waits or is sent; s_tready drops only while both banks
//   hold finished messages. m_tvalid rises once the queue holds the
//   finished message and the back end has read its first byte; then one
//   byte goes per cycle while m_tready is high; between messages the
//   registered store read of the next message's first byte leaves a gap.
//   A stall on m_tready holds the current byte; the input keeps running
//   until both banks are full.
//   Synchronous reset drops any partial or waiting message and returns to
//   waiting for a status byte.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_message_framer_top
  import mmf_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] midi_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // msg_last
  output logic            m_tuser    // [0] truncated
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  queue_status_t qstat;
  desc_t         push_desc;
  logic          push, pop;
  logic          wr_en, rd_en;
  logic [AW:0]   wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // framing front end
  mmf_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat    (qstat),
    .push     (push),
    .push_desc(push_desc),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // finished message queue
  mmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .qstat    (qstat)
  );

  // two-bank message store
  mmf_ram #(
    .WIDTH(8),
    .DEPTH(2 ** (AW + 1))
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output back end
  mmf_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .pop     (pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/mmf_checker.sv
// ----------------------------------------------------------------------------
// mmf_checker
// Port-level checks on the framer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmf_checker
  import mmf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // a stalled output item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                              $stable(m_tuser))
    else $error("output item changed while stalled");

  // a message is sent as an unbroken burst with one truncation mark
  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser)))
    else $error("message burst broken or truncation mark changed");

  // a cut SysEx message still ends in its end byte
  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tlast |-> m_tdata == ST_SYSEX_END)
    else $error("truncated message does not end in 0xF7");

  // nothing is sent right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind midi_message_framer_top mmf_checker u_mmf_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks midi_message_framer_top. A raw MIDI byte stream is fed in: a short
// directed run (dropped bytes, each message kind, status bytes inside
// messages, empty and overflowing SysEx), then random messages with some
// noise and broken messages. A framing predictor builds the bytes each
// message must come out as, and every output item is checked against them
// in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import mmf_pkg::*;

  localparam int DEPTH          = DEFAULT_BUFFER_DEPTH;
  localparam int RANDOM_BYTES   = 190;
  localparam int IDLE_PERCENT   = 28;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int REPORT_LIMIT   = 10;

  // one pending input item, or a pause until all output has drained
  typedef struct {
    bit         hold;
    logic [7:0] value;
  } raw_item_t;

  // one expected output item
  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       cut;
  } framed_byte_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  raw_item_t    raw_pending[$];
  framed_byte_t framed_due[$];
  int mismatches   = 0;
  int bytes_fed    = 0;
  int quiet_cycles = 0;
  logic calm;

  // framing predictor state
  front_state_t frame_mode = FR_IDLE;
  logic [1:0]   frame_len  = 2'd0;
  logic [7:0]   frame_store [DEPTH];
  int           frame_fill = 0;
  logic         frame_cut  = 1'b0;

  // driver and monitor temporaries
  logic         next_valid;
  logic [7:0]   next_data;
  framed_byte_t seen;

  midi_message_framer_top #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stretch with no idling on either side
  assign calm = (bytes_fed >= 100) && (bytes_fed < 180);

  // ---------------------------------------------------------------- predictor
  task automatic keep_byte(input logic [7:0] b);
    if (frame_fill < DEPTH) begin
      frame_store[frame_fill] = b;
      frame_fill++;
    end else begin
      frame_cut = 1'b1;
    end
  endtask

  task automatic release_frame();
    framed_byte_t fb;
    for (int k = 0; k < frame_fill; k++) begin
      fb.value = frame_store[k];
      fb.last  = (k == frame_fill - 1);
      fb.cut   = frame_cut;
      framed_due = {framed_due, fb};
    end
    frame_mode = FR_IDLE;
    frame_len  = 2'd0;
    frame_fill = 0;
    frame_cut  = 1'b0;
  endtask

  task automatic frame_byte(input logic [7:0] b);
    logic [3:0] hi;
    hi = b[7:4];
    case (frame_mode)
      FR_IDLE: begin
        if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_PRESS ||
            hi == HI_CTRL_CHANGE || hi == HI_PITCH_BEND) begin
          frame_len = LEN_THREE;
        end else if (hi == HI_PROG_CHANGE || hi == HI_CHAN_PRESS) begin
          frame_len = LEN_TWO;
        end else if (b == ST_SYSEX_START) begin
          frame_len = 2'd0;
        end else begin
          return;
        end
        frame_fill = 0;
        frame_cut  = 1'b0;
        keep_byte(b);
        if (frame_len == 2'd0) frame_mode = FR_SYSEX;
        else frame_mode = FR_FIXED;
      end
      FR_FIXED: begin
        keep_byte(b);
        if (frame_fill >= frame_len) release_frame();
      end
      FR_SYSEX: begin
        if (b == ST_SYSEX_END) begin
          // a full store keeps the end marker in its last slot
          if (frame_fill >= DEPTH) begin
            frame_cut = 1'b1;
            frame_store[DEPTH-1] = b;
          end else begin
            keep_byte(b);
          end
          release_frame();
        end else begin
          keep_byte(b);
        end
      end
      default: begin
        frame_mode = FR_IDLE;
        frame_len  = 2'd0;
        frame_fill = 0;
        frame_cut  = 1'b0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic put(input logic [7:0] b);
    raw_item_t r;
    r.hold  = 1'b0;
    r.value = b;
    raw_pending = {raw_pending, r};
  endtask

  task automatic put_hold();
    raw_item_t r;
    r.hold  = 1'b1;
    r.value = 8'h00;
    raw_pending = {raw_pending, r};
  endtask

  // mostly data bytes, now and then any byte
  function automatic logic [7:0] data_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic put_fixed(input logic [3:0] hi, input int n_data);
    put({hi, 4'($urandom_range(0, 15))});
    repeat (n_data) put(data_byte());
  endtask

  task automatic put_sysex(input int n_data);
    put(ST_SYSEX_START);
    repeat (n_data) put(data_byte());
    put(ST_SYSEX_END);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      next_valid = 1'b0;
      next_data  = s_tdata;
      if (s_tvalid && s_tready) begin
        frame_byte(s_tdata);
        bytes_fed <= bytes_fed + 1;
      end
      if (s_tvalid && !s_tready) begin
        next_valid = 1'b1;
      end else if (raw_pending.size() != 0) begin
        if (raw_pending[0].hold) begin
          if (framed_due.size() == 0) void'(raw_pending.pop_front());
        end else if (calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
          next_data  = raw_pending[0].value;
          next_valid = 1'b1;
          void'(raw_pending.pop_front());
        end
      end
      s_tvalid <= next_valid;
      s_tdata  <= next_data;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (framed_due.size() == 0) begin
          note_mismatch($sformatf("unexpected item byte %02h last %0b cut %0b",
                                  m_tdata, m_tlast, m_tuser));
        end else begin
          seen = framed_due.pop_front();
          if (m_tdata !== seen.value || m_tlast !== seen.last || m_tuser !== seen.cut) begin
            note_mismatch($sformatf(
              "byte exp %02h got %02h, last exp %0b got %0b, cut exp %0b got %0b",
              seen.value, m_tdata, seen.last, m_tlast, seen.cut, m_tuser));
          end
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int         random_bytes;
    int         pick;
    bit         held_mid;
    logic [3:0] hi3;
    logic [3:0] hi2;
    random_bytes = 0;
    held_mid     = 1'b0;

    // bytes that open no message are dropped
    put(8'h00);
    put(8'h7F);
    put(8'hF1);
    put(ST_SYSEX_END);
    put(8'hFF);
    // each fixed-length kind, channel and data extremes
    put({HI_NOTE_OFF, 4'h0});    put(8'h00); put(8'h7F);
    put({HI_NOTE_ON, 4'hF});     put(8'h7F); put(8'h00);
    put({HI_POLY_PRESS, 4'h5});  put(8'h55); put(8'h2A);
    put({HI_PITCH_BEND, 4'hA});  put(8'h01); put(8'h7E);
    put({HI_PROG_CHANGE, 4'h0}); put(8'h7F);
    // status bytes inside a message are kept as data
    put({HI_CTRL_CHANGE, 4'h7}); put(8'hFF); put(8'h80);
    put({HI_CHAN_PRESS, 4'hC});  put(ST_SYSEX_START);
    // empty sysex, then one carrying a status byte
    put(ST_SYSEX_START); put(ST_SYSEX_END);
    put(ST_SYSEX_START); put({HI_NOTE_ON, 4'h1}); put(8'hF8); put(ST_SYSEX_END);
    // sysex overflowing the store
    put_sysex(DEPTH + 6);
    put_hold();

    // random messages, some noise and broken messages
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0: hi3 = HI_NOTE_OFF;
        1: hi3 = HI_NOTE_ON;
        2: hi3 = HI_POLY_PRESS;
        3: hi3 = HI_CTRL_CHANGE;
        default: hi3 = HI_PITCH_BEND;
      endcase
      hi2 = $urandom_range(0, 1) ? HI_PROG_CHANGE : HI_CHAN_PRESS;
      if (pick < 40) begin
        put_fixed(hi3, 2);
        random_bytes += 3;
      end else if (pick < 60) begin
        put_fixed(hi2, 1);
        random_bytes += 2;
      end else if (pick < 80) begin
        // mostly short, now and then around the store size
        if ($urandom_range(0, 9) == 0) pick = $urandom_range(DEPTH - 3, DEPTH + 6);
        else pick = $urandom_range(0, 10);
        put_sysex(pick);
        random_bytes += pick + 2;
      end else if (pick < 90) begin
        put(8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 1);
        put_fixed(hi3, pick);
        random_bytes += pick + 1;
      end
      if (!held_mid && random_bytes >= RANDOM_BYTES / 2) begin
        put_hold();
        held_mid = 1'b1;
      end
    end
    // close anything left open
    put(ST_SYSEX_END);
    put_fixed(HI_NOTE_ON, 2);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (raw_pending.size() != 0 || s_tvalid) @(posedge clk);
    while (framed_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
